// ===== rtl/core/ttpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttpt_pkg
// Shared constants and types of the tape transport position tracker.
// ----------------------------------------------------------------------------
package ttpt_pkg;

    // Default geometry of the tape
    localparam int GAP_LEN_DEF        = 310;
    localparam int DATA_BLOCK_LEN_DEF = 1668;
    localparam int POSITION_BITS_DEF  = 20;

    // Field widths
    localparam int SPEED_W     = 8;
    localparam int MAXPOS_W    = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int TRACK_W     = 2;
    localparam int BLOCK_W     = 10;

    // Register reset values
    localparam logic [SPEED_W-1:0]  SLOW_SPEED_RST   = 8'd15;
    localparam logic [SPEED_W-1:0]  FAST_SPEED_RST   = 8'd45;
    localparam logic [MAXPOS_W-1:0] MAX_POSITION_RST = 20'd740000;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_SPEED   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_SPEED   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_POSITION = 2'd2;

    // Per-beat control flags handed from the motion stage to the block divider
    typedef struct packed {
        logic init;
        logic moving;
        logic at_begin;
        logic at_end;
        logic dma_busy;
        logic slow_fwd;
        logic cancel;
        logic load;
    } ctl_t;

endpackage

// ===== rtl/core/ttpt_motion.sv =====
// ----------------------------------------------------------------------------
// ttpt_motion
// Configuration registers, motion mode decode, position update with clamping
// and track latching. Registers the tick result for the block divider.
// ----------------------------------------------------------------------------
module ttpt_motion #(
    parameter int POSITION_BITS = ttpt_pkg::POSITION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ttpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ttpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               init_request,
    input  logic                               slow_forward,
    input  logic                               fast_forward,
    input  logic                               slow_reverse,
    input  logic                               fast_reverse,
    input  logic [ttpt_pkg::TRACK_W-1:0]       read_track_request,
    input  logic [ttpt_pkg::TRACK_W-1:0]       write_track_request,
    input  logic                               dma_busy,
    input  logic                               down_ready,
    output logic                               s1_valid,
    output ttpt_pkg::ctl_t                     s1_ctl,
    output logic [POSITION_BITS-1:0]           s1_pos,
    output logic [ttpt_pkg::TRACK_W-1:0]       s1_read_track,
    output logic [ttpt_pkg::TRACK_W-1:0]       s1_write_track
);
    import ttpt_pkg::*;

    localparam int WIDE_W = POSITION_BITS + 2;
    localparam logic [POSITION_BITS-1:0] POS_MASK = '1;

    // Motion mode codes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SF   = 3'd1;
    localparam logic [2:0] MODE_FF   = 3'd2;
    localparam logic [2:0] MODE_SR   = 3'd3;
    localparam logic [2:0] MODE_FR   = 3'd4;

    logic [SPEED_W-1:0]       slow_speed_reg;
    logic [SPEED_W-1:0]       fast_speed_reg;
    logic [MAXPOS_W-1:0]      max_position_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [2:0]               mode_reg;
    logic [TRACK_W-1:0]       read_track_reg;
    logic [TRACK_W-1:0]       write_track_reg;

    logic                     s1_valid_reg;
    ctl_t                     s1_ctl_reg;
    logic [POSITION_BITS-1:0] s1_pos_reg;
    logic [TRACK_W-1:0]       s1_read_track_reg;
    logic [TRACK_W-1:0]       s1_write_track_reg;

    logic [2:0]               mode_next;
    logic [POSITION_BITS-1:0] limit;
    logic signed [WIDE_W-1:0] pos_ext;
    logic signed [WIDE_W-1:0] slow_ext;
    logic signed [WIDE_W-1:0] fast_ext;
    logic signed [WIDE_W-1:0] pos_wide;
    logic signed [WIDE_W-1:0] pos_floor;
    logic                     begin_hit;
    logic                     end_hit;
    logic [POSITION_BITS-1:0] pos_next;
    logic [TRACK_W-1:0]       read_track_next;
    logic [TRACK_W-1:0]       write_track_next;
    logic                     accept;
    ctl_t                     ctl_next;

    assign in_ready = !s1_valid_reg || down_ready;
    assign accept   = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_speed_reg   <= SLOW_SPEED_RST;
            fast_speed_reg   <= FAST_SPEED_RST;
            max_position_reg <= MAX_POSITION_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLOW_SPEED:   slow_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_FAST_SPEED:   fast_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_MAX_POSITION: max_position_reg <= cfg_data[MAXPOS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Limit never exceeds the position range
    always_comb
    begin
        if (32'(max_position_reg) > 32'(POS_MASK))
            limit = POS_MASK;
        else
            limit = POSITION_BITS'(max_position_reg);
    end

    // Command priority: slow forward, fast forward, slow reverse, fast reverse
    always_comb
    begin
        priority if (slow_forward) mode_next = MODE_SF;
        else if (fast_forward)     mode_next = MODE_FF;
        else if (slow_reverse)     mode_next = MODE_SR;
        else if (fast_reverse)     mode_next = MODE_FR;
        else                       mode_next = MODE_IDLE;
    end

    // Position step, only when the mode is unchanged, then clamp both ends
    always_comb
    begin
        pos_ext  = signed'({2'b00, pos_reg});
        slow_ext = signed'({{(WIDE_W-SPEED_W){1'b0}}, slow_speed_reg});
        fast_ext = signed'({{(WIDE_W-SPEED_W){1'b0}}, fast_speed_reg});
        pos_wide = pos_ext;
        if (mode_next == mode_reg)
        begin
            unique case (mode_next)
                MODE_SF: pos_wide = pos_ext + slow_ext;
                MODE_FF: pos_wide = pos_ext + fast_ext;
                MODE_SR: pos_wide = pos_ext - slow_ext;
                MODE_FR: pos_wide = pos_ext - fast_ext;
                default: pos_wide = pos_ext;
            endcase
        end
        begin_hit = (pos_wide <= 0);
        pos_floor = begin_hit ? '0 : pos_wide;
        end_hit   = (pos_floor >= signed'({2'b00, limit}));
        pos_next  = end_hit ? limit : pos_floor[POSITION_BITS-1:0];
    end

    // Tracks follow the request only while no transfer runs and no init is requested
    assign read_track_next  = (init_request || dma_busy) ? read_track_reg
                                                         : read_track_request;
    assign write_track_next = (init_request || dma_busy) ? write_track_reg
                                                         : write_track_request;

    always_comb
    begin
        ctl_next.init     = init_request;
        ctl_next.moving   = (mode_next != MODE_IDLE);
        ctl_next.at_begin = begin_hit;
        ctl_next.at_end   = end_hit;
        ctl_next.dma_busy = dma_busy;
        ctl_next.slow_fwd = !init_request && (mode_next == MODE_SF);
        ctl_next.cancel   = init_request || (mode_next != MODE_SF);
        ctl_next.load     = init_request || (mode_next == MODE_SF)
                            || (mode_next == MODE_IDLE);
    end

    // Tracker state; init clears position and keeps mode and tracks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            mode_reg        <= MODE_IDLE;
            read_track_reg  <= '0;
            write_track_reg <= '0;
        end
        else if (accept)
        begin
            read_track_reg  <= read_track_next;
            write_track_reg <= write_track_next;
            if (init_request)
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
            end
        end
    end

    // Stage register towards the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg         <= ctl_next;
            s1_pos_reg         <= init_request ? '0 : pos_next;
            s1_read_track_reg  <= read_track_next;
            s1_write_track_reg <= write_track_next;
        end
    end

    assign s1_valid       = s1_valid_reg;
    assign s1_ctl         = s1_ctl_reg;
    assign s1_pos         = s1_pos_reg;
    assign s1_read_track  = s1_read_track_reg;
    assign s1_write_track = s1_write_track_reg;

endmodule

// ===== rtl/core/ttpt_block_div.sv =====
// ----------------------------------------------------------------------------
// ttpt_block_div
// Splits the position into block number and offset by a reciprocal multiply
// with one correction step, forms the request flags and holds the result.
// ----------------------------------------------------------------------------
module ttpt_block_div #(
    parameter int POSITION_BITS  = ttpt_pkg::POSITION_BITS_DEF,
    parameter int GAP_LEN        = ttpt_pkg::GAP_LEN_DEF,
    parameter int DATA_BLOCK_LEN = ttpt_pkg::DATA_BLOCK_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s1_valid,
    output logic                           up_ready,
    input  ttpt_pkg::ctl_t                 s1_ctl,
    input  logic [POSITION_BITS-1:0]       s1_pos,
    input  logic [ttpt_pkg::TRACK_W-1:0]   s1_read_track,
    input  logic [ttpt_pkg::TRACK_W-1:0]   s1_write_track,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           moving,
    output logic                           at_begin,
    output logic                           at_end,
    output logic                           data_detect,
    output logic                           send_request,
    output logic                           cancel_request,
    output logic                           load_request,
    output logic [ttpt_pkg::BLOCK_W-1:0]   block_index,
    output logic [ttpt_pkg::TRACK_W-1:0]   read_track_now,
    output logic [ttpt_pkg::TRACK_W-1:0]   write_track_now,
    output logic [POSITION_BITS-1:0]       position_now
);
    import ttpt_pkg::*;

    localparam int PERIOD   = GAP_LEN + DATA_BLOCK_LEN;
    localparam int PERIOD_W = $clog2(PERIOD + 1);
    localparam int PROD_W   = 2 * POSITION_BITS;
    localparam int QD_W     = POSITION_BITS + PERIOD_W;
    // floor(2^P / period): estimate is exact or one low
    localparam logic [POSITION_BITS-1:0] RECIP    = POSITION_BITS'((2 ** POSITION_BITS) / PERIOD);
    localparam logic [PERIOD_W-1:0]      PERIOD_C = PERIOD_W'(PERIOD);

    typedef struct packed {
        logic moving;
        logic at_begin;
        logic at_end;
        logic data_detect;
    } status_t;

    // Stage 2: reciprocal product
    logic                     v2_reg;
    ctl_t                     ctl2_reg;
    logic [POSITION_BITS-1:0] pos2_reg;
    logic [TRACK_W-1:0]       rd2_reg;
    logic [TRACK_W-1:0]       wr2_reg;
    logic [PROD_W-1:0]        prod2_reg;
    // Stage 3: estimate times period
    logic                     v3_reg;
    ctl_t                     ctl3_reg;
    logic [POSITION_BITS-1:0] pos3_reg;
    logic [TRACK_W-1:0]       rd3_reg;
    logic [TRACK_W-1:0]       wr3_reg;
    logic [POSITION_BITS-1:0] q3_reg;
    logic [QD_W-1:0]          qd3_reg;
    // Result register
    logic                     vo_reg;
    status_t                  flags_reg;
    logic                     send_reg;
    logic                     cancel_reg;
    logic                     load_reg;
    logic [BLOCK_W-1:0]       block_reg;
    logic [TRACK_W-1:0]       rd_o_reg;
    logic [TRACK_W-1:0]       wr_o_reg;
    logic [POSITION_BITS-1:0] pos_o_reg;
    // Flags of the last non-init tick
    status_t                  status_reg;

    logic                     en_o;
    logic                     en3;
    logic                     en2;
    logic [POSITION_BITS-1:0] q_est;
    logic [POSITION_BITS-1:0] offs_raw;
    logic                     fix;
    logic [POSITION_BITS-1:0] q_fin;
    logic [POSITION_BITS-1:0] offs_fin;
    logic                     past_gap;
    status_t                  flags_next;
    logic                     send_next;
    logic                     cancel_next;
    logic                     load_next;
    logic [BLOCK_W-1:0]       block_next;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en_o     = !vo_reg || out_ready;
    assign en3      = !v3_reg || en_o;
    assign en2      = !v2_reg || en3;
    assign up_ready = en2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en2)
                v2_reg <= s1_valid;
            if (en3)
                v3_reg <= v2_reg;
            if (en_o)
                vo_reg <= v3_reg;
        end
    end

    // Position times reciprocal
    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid)
        begin
            ctl2_reg  <= s1_ctl;
            pos2_reg  <= s1_pos;
            rd2_reg   <= s1_read_track;
            wr2_reg   <= s1_write_track;
            prod2_reg <= PROD_W'(s1_pos) * PROD_W'(RECIP);
        end
    end

    assign q_est = prod2_reg[PROD_W-1:POSITION_BITS];

    // Quotient estimate times period
    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            ctl3_reg <= ctl2_reg;
            pos3_reg <= pos2_reg;
            rd3_reg  <= rd2_reg;
            wr3_reg  <= wr2_reg;
            q3_reg   <= q_est;
            qd3_reg  <= QD_W'(q_est) * QD_W'(PERIOD_C);
        end
    end

    // Remainder with one correction step, then the request flags
    always_comb
    begin
        offs_raw = pos3_reg - qd3_reg[POSITION_BITS-1:0];
        fix      = (32'(offs_raw) >= 32'(PERIOD));
        q_fin    = fix ? q3_reg + 1'b1 : q3_reg;
        offs_fin = fix ? offs_raw - POSITION_BITS'(PERIOD) : offs_raw;
        past_gap = (32'(offs_fin) > 32'(GAP_LEN));

        if (ctl3_reg.init)
        begin
            flags_next  = status_reg;
            send_next   = 1'b0;
            cancel_next = 1'b1;
            load_next   = 1'b1;
            block_next  = '0;
        end
        else
        begin
            flags_next.moving      = ctl3_reg.moving;
            flags_next.at_begin    = ctl3_reg.at_begin;
            flags_next.at_end      = ctl3_reg.at_end;
            flags_next.data_detect = past_gap || ctl3_reg.dma_busy;
            send_next   = ctl3_reg.slow_fwd && !ctl3_reg.dma_busy && past_gap;
            cancel_next = ctl3_reg.cancel;
            load_next   = ctl3_reg.load;
            block_next  = q_fin[BLOCK_W-1:0];
        end
    end

    // Held status flags, replayed on init ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= '0;
        else if (en_o && v3_reg && !ctl3_reg.init)
            status_reg <= flags_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (en_o && v3_reg)
        begin
            flags_reg  <= flags_next;
            send_reg   <= send_next;
            cancel_reg <= cancel_next;
            load_reg   <= load_next;
            block_reg  <= block_next;
            rd_o_reg   <= rd3_reg;
            wr_o_reg   <= wr3_reg;
            pos_o_reg  <= pos3_reg;
        end
    end

    assign out_valid       = vo_reg;
    assign moving          = flags_reg.moving;
    assign at_begin        = flags_reg.at_begin;
    assign at_end          = flags_reg.at_end;
    assign data_detect     = flags_reg.data_detect;
    assign send_request    = send_reg;
    assign cancel_request  = cancel_reg;
    assign load_request    = load_reg;
    assign block_index     = block_reg;
    assign read_track_now  = rd_o_reg;
    assign write_track_now = wr_o_reg;
    assign position_now    = pos_o_reg;

endmodule

// ===== rtl/core/tape_transport_position_tracker.sv =====
// Beats pass the stage register, product and estimate stages, result register.
// Throughput: one tick per cycle unless out_ready stalls; position and mode update
// at accept; the divider (two registered multiplies, a correction) follows.
// Reset (rst_n, asynchronous, active low): position 0, mode idle, tracks 0,
// held status flags 0, registers to 15 / 45 / 740000, pipeline empty.
// ----------------------------------------------------------------------------
// tape_transport_position_tracker
// Tape position tracker: one beat per transport tick, one result per beat.
// ----------------------------------------------------------------------------
module tape_transport_position_tracker #(
    parameter int POSITION_BITS  = ttpt_pkg::POSITION_BITS_DEF,
    parameter int GAP_LEN        = ttpt_pkg::GAP_LEN_DEF,
    parameter int DATA_BLOCK_LEN = ttpt_pkg::DATA_BLOCK_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ttpt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ttpt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               init_request,
    input  logic                               slow_forward,
    input  logic                               fast_forward,
    input  logic                               slow_reverse,
    input  logic                               fast_reverse,
    input  logic [ttpt_pkg::TRACK_W-1:0]       read_track_request,
    input  logic [ttpt_pkg::TRACK_W-1:0]       write_track_request,
    input  logic                               dma_busy,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               moving,
    output logic                               at_begin,
    output logic                               at_end,
    output logic                               data_detect,
    output logic                               send_request,
    output logic                               cancel_request,
    output logic                               load_request,
    output logic [ttpt_pkg::BLOCK_W-1:0]       block_index,
    output logic [ttpt_pkg::TRACK_W-1:0]       read_track_now,
    output logic [ttpt_pkg::TRACK_W-1:0]       write_track_now,
    output logic [POSITION_BITS-1:0]           position_now
);
    import ttpt_pkg::*;

    logic                     div_ready;
    logic                     s1_valid;
    ctl_t                     s1_ctl;
    logic [POSITION_BITS-1:0] s1_pos;
    logic [TRACK_W-1:0]       s1_read_track;
    logic [TRACK_W-1:0]       s1_write_track;

    // Motion and position update
    ttpt_motion #(
        .POSITION_BITS (POSITION_BITS)
    ) u_motion (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .init_request        (init_request),
        .slow_forward        (slow_forward),
        .fast_forward        (fast_forward),
        .slow_reverse        (slow_reverse),
        .fast_reverse        (fast_reverse),
        .read_track_request  (read_track_request),
        .write_track_request (write_track_request),
        .dma_busy            (dma_busy),
        .down_ready          (div_ready),
        .s1_valid            (s1_valid),
        .s1_ctl              (s1_ctl),
        .s1_pos              (s1_pos),
        .s1_read_track       (s1_read_track),
        .s1_write_track      (s1_write_track)
    );

    // Block number, offset and request flags
    ttpt_block_div #(
        .POSITION_BITS  (POSITION_BITS),
        .GAP_LEN        (GAP_LEN),
        .DATA_BLOCK_LEN (DATA_BLOCK_LEN)
    ) u_block_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid),
        .up_ready        (div_ready),
        .s1_ctl          (s1_ctl),
        .s1_pos          (s1_pos),
        .s1_read_track   (s1_read_track),
        .s1_write_track  (s1_write_track),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .moving          (moving),
        .at_begin        (at_begin),
        .at_end          (at_end),
        .data_detect     (data_detect),
        .send_request    (send_request),
        .cancel_request  (cancel_request),
        .load_request    (load_request),
        .block_index     (block_index),
        .read_track_now  (read_track_now),
        .write_track_now (write_track_now),
        .position_now    (position_now)
    );

endmodule

// ===== rtl/core/ttpt_checker.sv =====
// ----------------------------------------------------------------------------
// ttpt_checker
// Port-level checks of the position tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ttpt_checker #(
    parameter int POSITION_BITS = ttpt_pkg::POSITION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           moving,
    input  logic                           at_begin,
    input  logic                           at_end,
    input  logic                           data_detect,
    input  logic                           send_request,
    input  logic                           cancel_request,
    input  logic                           load_request,
    input  logic [ttpt_pkg::BLOCK_W-1:0]   block_index,
    input  logic [ttpt_pkg::TRACK_W-1:0]   read_track_now,
    input  logic [ttpt_pkg::TRACK_W-1:0]   write_track_now,
    input  logic [POSITION_BITS-1:0]       position_now
);
    import ttpt_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position_now)
            && $stable(block_index) && $stable(read_track_now)
            && $stable(write_track_now) && $stable(at_end))
        else $error("result beat changed while stalled");

    // Beginning of tape means position zero
    a_begin_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_begin |-> position_now == '0)
        else $error("at_begin with non-zero position");

    // Sending only in slow forward past the gap
    a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_request |-> !cancel_request && load_request
            && data_detect && moving)
        else $error("send_request outside slow forward");

    // Idle tape never sends and always preloads
    a_idle_req: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moving |-> load_request && !send_request)
        else $error("request flags wrong while idle");

endmodule

bind tape_transport_position_tracker ttpt_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_ttpt_checker (.*);

// ===== verif/tape_transport_position_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_transport_position_tracker_tb
// Self-checking bench for the tape position tracker. Motion, init and track
// beats go in; every result beat is checked against an in-bench copy of the
// tracker state (position, mode, tracks, held flags). It runs a directed set,
// a back-pressure burst and three random phases under several register sets.
// ----------------------------------------------------------------------------
module tape_transport_position_tracker_tb;

    import ttpt_pkg::*;

    localparam int POS_W       = POSITION_BITS_DEF;
    localparam int TAPE_PERIOD = GAP_LEN_DEF + DATA_BLOCK_LEN_DEF;
    localparam int LATENCY     = 4;
    localparam int STALL_LIMIT = 5000;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_SLOW_FWD = 3'd1,
        MODE_FAST_FWD = 3'd2,
        MODE_SLOW_REV = 3'd3,
        MODE_FAST_REV = 3'd4
    } motion_e;

    // One transport tick as offered on the input channel
    typedef struct packed {
        logic               init;
        logic               slow_fwd;
        logic               fast_fwd;
        logic               slow_rev;
        logic               fast_rev;
        logic [TRACK_W-1:0] rd_track;
        logic [TRACK_W-1:0] wr_track;
        logic               dma;
    } tick_t;

    // What the tracker reports for one tick
    typedef struct packed {
        logic               moving;
        logic               at_begin;
        logic               at_end;
        logic               data_detect;
        logic               send_request;
        logic               cancel_request;
        logic               load_request;
        logic [BLOCK_W-1:0] block_index;
        logic [TRACK_W-1:0] rd_latched;
        logic [TRACK_W-1:0] wr_latched;
        logic [POS_W-1:0]   position;
    } tick_result_t;

    // DUT connections
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   init_request = 1'b0;
    logic                   slow_forward = 1'b0;
    logic                   fast_forward = 1'b0;
    logic                   slow_reverse = 1'b0;
    logic                   fast_reverse = 1'b0;
    logic [TRACK_W-1:0]     read_track_request = '0;
    logic [TRACK_W-1:0]     write_track_request = '0;
    logic                   dma_busy = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   moving;
    logic                   at_begin;
    logic                   at_end;
    logic                   data_detect;
    logic                   send_request;
    logic                   cancel_request;
    logic                   load_request;
    logic [BLOCK_W-1:0]     block_index;
    logic [TRACK_W-1:0]     read_track_now;
    logic [TRACK_W-1:0]     write_track_now;
    logic [POS_W-1:0]       position_now;

    // Tracker copy: registers and state
    logic [SPEED_W-1:0]  trk_slow_speed;
    logic [SPEED_W-1:0]  trk_fast_speed;
    logic [MAXPOS_W-1:0] trk_max_pos;
    logic [POS_W-1:0]    trk_pos;
    motion_e             trk_mode;
    logic [TRACK_W-1:0]  trk_rd_track;
    logic [TRACK_W-1:0]  trk_wr_track;
    logic [3:0]          trk_flags;     // {data_detect, at_end, at_begin, moving}

    tick_result_t expected_tick_results[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int recv_hold_left = 0;
    int stall_cycles   = 0;

    tape_transport_position_tracker u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .init_request        (init_request),
        .slow_forward        (slow_forward),
        .fast_forward        (fast_forward),
        .slow_reverse        (slow_reverse),
        .fast_reverse        (fast_reverse),
        .read_track_request  (read_track_request),
        .write_track_request (write_track_request),
        .dma_busy            (dma_busy),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .moving              (moving),
        .at_begin            (at_begin),
        .at_end              (at_end),
        .data_detect         (data_detect),
        .send_request        (send_request),
        .cancel_request      (cancel_request),
        .load_request        (load_request),
        .block_index         (block_index),
        .read_track_now      (read_track_now),
        .write_track_now     (write_track_now),
        .position_now        (position_now)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Tracker prediction
    // ------------------------------------------------------------------------
    function automatic void reset_tracker_copy();
        trk_slow_speed = SLOW_SPEED_RST;
        trk_fast_speed = FAST_SPEED_RST;
        trk_max_pos    = MAX_POSITION_RST;
        trk_pos        = '0;
        trk_mode       = MODE_IDLE;
        trk_rd_track   = '0;
        trk_wr_track   = '0;
        trk_flags      = '0;
    endfunction

    function automatic tick_result_t predict_tick(input tick_t t);
        tick_result_t r;
        motion_e      next_mode;
        int           p;
        int unsigned  blk;
        int unsigned  offs;
        r = '0;
        // init: position back to zero, flags, mode and tracks held
        if (t.init)
        begin
            trk_pos          = '0;
            r.moving         = trk_flags[0];
            r.at_begin       = trk_flags[1];
            r.at_end         = trk_flags[2];
            r.data_detect    = trk_flags[3];
            r.cancel_request = 1'b1;
            r.load_request   = 1'b1;
            r.rd_latched     = trk_rd_track;
            r.wr_latched     = trk_wr_track;
            return r;
        end
        // priority: slow fwd, fast fwd, slow rev, fast rev
        if (t.slow_fwd)      next_mode = MODE_SLOW_FWD;
        else if (t.fast_fwd) next_mode = MODE_FAST_FWD;
        else if (t.slow_rev) next_mode = MODE_SLOW_REV;
        else if (t.fast_rev) next_mode = MODE_FAST_REV;
        else                 next_mode = MODE_IDLE;
        // move only when the mode is held from the previous tick
        p = int'(trk_pos);
        if (next_mode == trk_mode)
        begin
            case (next_mode)
                MODE_SLOW_FWD: p = p + int'(trk_slow_speed);
                MODE_FAST_FWD: p = p + int'(trk_fast_speed);
                MODE_SLOW_REV: p = p - int'(trk_slow_speed);
                MODE_FAST_REV: p = p - int'(trk_fast_speed);
                default: ;
            endcase
        end
        trk_mode = next_mode;
        // clamp at both ends of the tape
        r.moving   = (next_mode != MODE_IDLE);
        r.at_begin = (p <= 0);
        if (r.at_begin) p = 0;
        r.at_end = (p >= int'(trk_max_pos));
        if (r.at_end) p = int'(trk_max_pos);
        trk_pos = p[POS_W-1:0];
        // block number and offset inside the block (gap first)
        blk  = int'(trk_pos) / TAPE_PERIOD;
        offs = int'(trk_pos) - blk * TAPE_PERIOD;
        r.data_detect = (offs > GAP_LEN_DEF) || t.dma;
        if (!t.dma)
        begin
            trk_rd_track = t.rd_track;
            trk_wr_track = t.wr_track;
        end
        r.send_request   = (next_mode == MODE_SLOW_FWD) && !t.dma && (offs > GAP_LEN_DEF);
        r.cancel_request = (next_mode != MODE_SLOW_FWD);
        r.load_request   = (next_mode == MODE_SLOW_FWD) || (next_mode == MODE_IDLE);
        r.block_index    = blk[BLOCK_W-1:0];
        r.rd_latched     = trk_rd_track;
        r.wr_latched     = trk_wr_track;
        r.position       = trk_pos;
        trk_flags = {r.data_detect, r.at_end, r.at_begin, r.moving};
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        tick_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tick_results.size() == 0)
                begin
                    $error("result beat with no tick outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tick_results.pop_front();
                    compare_field("moving", 32'(want.moving), 32'(moving));
                    compare_field("at_begin", 32'(want.at_begin), 32'(at_begin));
                    compare_field("at_end", 32'(want.at_end), 32'(at_end));
                    compare_field("data_detect", 32'(want.data_detect),
                                  32'(data_detect));
                    compare_field("send_request", 32'(want.send_request),
                                  32'(send_request));
                    compare_field("cancel_request", 32'(want.cancel_request),
                                  32'(cancel_request));
                    compare_field("load_request", 32'(want.load_request),
                                  32'(load_request));
                    compare_field("block_index", 32'(want.block_index),
                                  32'(block_index));
                    compare_field("read_track_now", 32'(want.rd_latched),
                                  32'(read_track_now));
                    compare_field("write_track_now", 32'(want.wr_latched),
                                  32'(write_track_now));
                    compare_field("position_now", 32'(want.position),
                                  32'(position_now));
                end
            end
            // long hold-off first, otherwise random stalls
            if (recv_hold_left > 0)
            begin
                out_ready <= 1'b0;
                recv_hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        // random gap before the beat
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid            <= 1'b1;
        init_request        <= t.init;
        slow_forward        <= t.slow_fwd;
        fast_forward        <= t.fast_fwd;
        slow_reverse        <= t.slow_rev;
        fast_reverse        <= t.fast_rev;
        read_track_request  <= t.rd_track;
        write_track_request <= t.wr_track;
        dma_busy            <= t.dma;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_tick_results.push_back(predict_tick(t));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_ticks();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_tick_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SLOW_SPEED:   trk_slow_speed = data[SPEED_W-1:0];
            REG_FAST_SPEED:   trk_fast_speed = data[SPEED_W-1:0];
            REG_MAX_POSITION: trk_max_pos    = data[MAXPOS_W-1:0];
            default: ;
        endcase
    endtask

    // Only called with the tracker drained
    task automatic configure_tracker(input int slow, input int fast, input int max_pos);
        write_reg(REG_SLOW_SPEED, CFG_DATA_W'(slow));
        write_reg(REG_FAST_SPEED, CFG_DATA_W'(fast));
        write_reg(REG_MAX_POSITION, CFG_DATA_W'(max_pos));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic tick_t cmd_tick(input motion_e cmd, input logic [TRACK_W-1:0] rd,
                                       input logic [TRACK_W-1:0] wr, input logic dma);
        tick_t t;
        t          = '0;
        t.slow_fwd = (cmd == MODE_SLOW_FWD);
        t.fast_fwd = (cmd == MODE_FAST_FWD);
        t.slow_rev = (cmd == MODE_SLOW_REV);
        t.fast_rev = (cmd == MODE_FAST_REV);
        t.rd_track = rd;
        t.wr_track = wr;
        t.dma      = dma;
        return t;
    endfunction

    // Mostly held motion runs with random content, some raw noise
    task automatic run_random_ticks(input int count);
        int      sent;
        int      run_len;
        motion_e cmd;
        tick_t   t;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                cmd     = motion_e'($urandom_range(4));
                run_len = $urandom_range(1, 40);
                for (int i = 0; i < run_len && sent < count; i++)
                begin
                    t = cmd_tick(cmd, TRACK_W'($urandom_range(3)),
                                 TRACK_W'($urandom_range(3)),
                                 $urandom_range(99) < 25);
                    // lower-priority commands alongside, which must lose
                    if ($urandom_range(99) < 20)
                    begin
                        if (cmd == MODE_SLOW_FWD) t.fast_fwd = 1'($urandom_range(1));
                        if (cmd <= MODE_FAST_FWD && cmd != MODE_IDLE)
                            t.slow_rev = 1'($urandom_range(1));
                        if (cmd <= MODE_SLOW_REV && cmd != MODE_IDLE)
                            t.fast_rev = 1'($urandom_range(1));
                    end
                    if ($urandom_range(99) < 2) t.init = 1'b1;
                    send_tick(t);
                    sent++;
                end
            end
            else
            begin
                t = tick_t'($urandom_range(1023));
                send_tick(t);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_ticks();
        tick_t t;
        send_idle_pct = 31;
        recv_idle_pct = 48;
        // reset registers: idle at zero, then each mode, priority and clamp
        send_tick(cmd_tick(MODE_IDLE, 2'd3, 2'd3, 1'b0));
        send_tick(cmd_tick(MODE_SLOW_FWD, 2'd0, 2'd0, 1'b1));   // tracks held
        send_tick(cmd_tick(MODE_SLOW_FWD, 2'd1, 2'd2, 1'b0));
        t = cmd_tick(MODE_SLOW_FWD, 2'd2, 2'd1, 1'b0);
        t.fast_fwd = 1'b1;
        t.slow_rev = 1'b1;
        t.fast_rev = 1'b1;
        send_tick(t);
        t = cmd_tick(MODE_FAST_FWD, 2'd0, 2'd3, 1'b0);
        t.slow_rev = 1'b1;
        t.fast_rev = 1'b1;
        send_tick(t);                                           // mode change, no move
        send_tick(t);
        t = cmd_tick(MODE_SLOW_REV, 2'd3, 2'd0, 1'b0);
        t.fast_rev = 1'b1;
        send_tick(t);
        send_tick(t);
        send_tick(cmd_tick(MODE_FAST_REV, 2'd1, 2'd1, 1'b0));
        send_tick(cmd_tick(MODE_FAST_REV, 2'd1, 2'd1, 1'b0));
        send_tick(cmd_tick(MODE_FAST_REV, 2'd1, 2'd1, 1'b0));   // clamp at beginning
        t = cmd_tick(MODE_SLOW_FWD, 2'd2, 2'd2, 1'b1);
        t.init = 1'b1;
        send_tick(t);                                           // init holds flags
        drain_ticks();

        // fast tape, short end: send request past the gap, end clamp
        configure_tracker(255, 255, 2100);
        repeat (4) send_tick(cmd_tick(MODE_SLOW_FWD, 2'd1, 2'd0, 1'b0));
        send_tick(cmd_tick(MODE_SLOW_FWD, 2'd1, 2'd0, 1'b1));
        repeat (7) send_tick(cmd_tick(MODE_FAST_FWD, 2'd2, 2'd3, 1'b0));
        drain_ticks();

        // lowered end clamps while idle, then zero length tape
        configure_tracker(255, 255, 1000);
        send_tick(cmd_tick(MODE_IDLE, 2'd0, 2'd1, 1'b0));
        drain_ticks();
        configure_tracker(0, 0, 0);
        send_tick(cmd_tick(MODE_IDLE, 2'd3, 2'd2, 1'b0));
        t = '0;
        t.init = 1'b1;
        send_tick(t);
        drain_ticks();
        configure_tracker(0, 0, 1048575);
        repeat (2) send_tick(cmd_tick(MODE_SLOW_FWD, 2'd0, 2'd0, 1'b0));
        drain_ticks();
    endtask

    // Receiver holds off while ticks keep coming, so the input must stall
    task automatic test_output_backpressure();
        configure_tracker(200, 100, 9000);
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        recv_hold_left = 200;
        run_random_ticks(80);
        drain_ticks();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int slow, input int fast, input int max_pos,
                                       input int count);
        configure_tracker(slow, fast, max_pos);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_random_ticks(count);
        drain_ticks();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_tracker_copy();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ticks();
        test_output_backpressure();
        test_random_traffic(31, 48, 0, 255, 1048575, 560);
        test_random_traffic(48, 31, 255, 1, 20000, 560);
        test_random_traffic(0, 0, $urandom_range(255), $urandom_range(255), 5000, 560);

        repeat (LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0 && expected_tick_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ttpt_pkg.sv
rtl/core/ttpt_motion.sv
rtl/core/ttpt_block_div.sv
rtl/core/tape_transport_position_tracker.sv
rtl/core/ttpt_checker.sv
verif/tape_transport_position_tracker_tb.sv
